@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RFRS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RFRS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rfrs_pkg.sv @@
`default_nettype none
package rfrs_pkg;

   localparam int DEFAULT_MIN_HEADER_BYTES = 26;
   localparam int DEFAULT_QUEUE_DEPTH      = 4;

   localparam logic [15:0]        ETHERTYPE_RESET = 16'h88B5;
   localparam logic signed [7:0]  RSSI_NONE       = -8'sd127;
   localparam logic [11:0]        SEQ_HALF        = 12'h800;

   // One classified frame on its way from the front to the back.
   typedef struct packed {
      logic              ok;
      logic [11:0]       len;
      logic [11:0]       seq;
      logic signed [7:0] rssi;
   } rfrs_item_type;

endpackage
`default_nettype wire

@@ hw/rtl/rfrs_if.sv @@
`default_nettype none
interface rfrs_req_if;
   logic              valid;
   logic              ready;
   logic              is_data_frame;
   logic [11:0]       frame_length;
   logic [7:0]        proto_high;
   logic [7:0]        proto_low;
   logic [15:0]       seq_control;
   logic signed [7:0] rssi_in;

   modport source (output valid, is_data_frame, frame_length, proto_high, proto_low,
                   seq_control, rssi_in, input ready);
   modport sink (input valid, is_data_frame, frame_length, proto_high, proto_low,
                 seq_control, rssi_in, output ready);
endinterface

interface rfrs_rsp_if;
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [31:0]       packets_total;
   logic [31:0]       bytes_total;
   logic [31:0]       lost_total;
   logic signed [7:0] rssi_last;

   modport source (output valid, accepted, packets_total, bytes_total, lost_total,
                   rssi_last, input ready);
   modport sink (input valid, accepted, packets_total, bytes_total, lost_total,
                 rssi_last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rfrs_front.sv @@
`default_nettype none
module rfrs_front #(
   parameter int MIN_HEADER_BYTES = rfrs_pkg::DEFAULT_MIN_HEADER_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rfrs_req_if.sink                   req_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data,
   output logic                       item_valid,
   output rfrs_pkg::rfrs_item_type    item,
   input  wire logic                  item_ready
);
   import rfrs_pkg::*;

   logic [15:0] ethertype_ff;
   logic [15:0] ethertype_in;
   logic        len_ok;
   logic        proto_ok;

   always_comb begin
      ethertype_in = csr_wr_en ? csr_wr_data : ethertype_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ethertype_ff <= ETHERTYPE_RESET;
      end else begin
         ethertype_ff <= ethertype_in;
      end
   end

   assign len_ok   = req_bus.frame_length >= 12'(MIN_HEADER_BYTES);
   assign proto_ok = (req_bus.proto_high == ethertype_ff[15:8])
                  && (req_bus.proto_low == ethertype_ff[7:0]);

   always_comb begin
      item.ok   = req_bus.is_data_frame && len_ok && proto_ok;
      item.len  = req_bus.frame_length;
      item.seq  = req_bus.seq_control[15:4];
      item.rssi = req_bus.rssi_in;
   end

   assign item_valid    = req_bus.valid;
   assign req_bus.ready = item_ready;

endmodule
`default_nettype wire

@@ hw/rtl/rfrs_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module rfrs_queue #(
   parameter int DEPTH = rfrs_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire rfrs_pkg::rfrs_item_type  in_item,
   output logic                          in_ready,
   output logic                          out_valid,
   output rfrs_pkg::rfrs_item_type       out_item,
   input  wire logic                     out_ready
);
   import rfrs_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   rfrs_item_type     slot_ff [DEPTH];
   logic [IdxW-1:0]   wr_ptr_ff;
   logic [IdxW-1:0]   wr_ptr_in;
   logic [IdxW-1:0]   rd_ptr_ff;
   logic [IdxW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              push;
   logic              pop;

   assign in_ready  = count_ff != CntW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IdxW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IdxW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   `RFRS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= CntW'(DEPTH), "queue overfilled")
   `RFRS_ASSERT_NXT(a_count_up, clock, reset, push && !pop,
      count_ff == $past(count_ff) + CntW'(1), "queue count missed a push")

endmodule
`default_nettype wire

@@ hw/rtl/rfrs_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module rfrs_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire rfrs_pkg::rfrs_item_type  item,
   output logic                          item_ready,
   rfrs_rsp_if.source                    rsp_bus
);
   import rfrs_pkg::*;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              accepted_ff;
   logic              accepted_in;
   logic [31:0]       pkt_ff;
   logic [31:0]       pkt_in;
   logic [31:0]       byte_ff;
   logic [31:0]       byte_in;
   logic [31:0]       lost_ff;
   logic [31:0]       lost_in;
   logic signed [7:0] rssi_ff;
   logic signed [7:0] rssi_in;
   logic [11:0]       prev_seq_ff;
   logic [11:0]       prev_seq_in;
   logic              have_seq_ff;
   logic              have_seq_in;
   logic              pop;
   logic [11:0]       gap;
   logic              gap_counts;

   // The statistics registers double as the result payload: they only move when a
   // new item enters the output register.
   assign item_ready = !rsp_valid_ff || rsp_bus.ready;
   assign pop        = item_valid && item_ready;
   assign gap        = item.seq - prev_seq_ff;
   assign gap_counts = have_seq_ff && (gap > 12'd1) && (gap < SEQ_HALF);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;
      pkt_in       = pkt_ff;
      byte_in      = byte_ff;
      lost_in      = lost_ff;
      rssi_in      = rssi_ff;
      prev_seq_in  = prev_seq_ff;
      have_seq_in  = have_seq_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         accepted_in  = item.ok;
         if (item.ok) begin
            pkt_in      = pkt_ff + 32'd1;
            byte_in     = byte_ff + {20'd0, item.len};
            rssi_in     = item.rssi;
            prev_seq_in = item.seq;
            have_seq_in = 1'b1;
            if (gap_counts) begin
               lost_in = lost_ff + {20'd0, gap - 12'd1};
            end
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
         pkt_ff       <= '0;
         byte_ff      <= '0;
         lost_ff      <= '0;
         rssi_ff      <= RSSI_NONE;
         prev_seq_ff  <= '0;
         have_seq_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
         pkt_ff       <= pkt_in;
         byte_ff      <= byte_in;
         lost_ff      <= lost_in;
         rssi_ff      <= rssi_in;
         prev_seq_ff  <= prev_seq_in;
         have_seq_ff  <= have_seq_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.accepted      = accepted_ff;
   assign rsp_bus.packets_total = pkt_ff;
   assign rsp_bus.bytes_total   = byte_ff;
   assign rsp_bus.lost_total    = lost_ff;
   assign rsp_bus.rssi_last     = rssi_ff;

   `RFRS_ASSERT_NXT(a_pkt_step, clock, reset, pop && item.ok, pkt_ff == $past(pkt_ff) + 32'd1, "packet count did not step on an accepted frame")
   `RFRS_ASSERT_NXT(a_reject_hold, clock, reset, pop && !item.ok, (lost_ff == $past(lost_ff)) && (byte_ff == $past(byte_ff)), "rejected frame changed the statistics")

endmodule
`default_nettype wire

@@ hw/rtl/raw_frame_rx_stats.sv @@
`default_nettype none
// Channel   Direction  Transfer when             Payload
// req_bus   in         req_bus.valid & ready     one received frame descriptor
// rsp_bus   out        rsp_bus.valid & ready     accepted flag and running statistics
// csr_*     in         csr_wr_en high            link_ethertype, no read-back
//
// One frame per cycle sustained while rsp_bus.ready is high; the statistics update is a
// registered step in the back end. A request passes through a queue slot and the back-end
// output register before its result is valid. Reset is synchronous; there is no clearing pass.
// The front end classifies against link_ethertype and writes a QUEUE_DEPTH-entry queue.
// When the result is stalled the queue fills, and req_bus.ready drops once it is full.
module raw_frame_rx_stats #(
   parameter int MIN_HEADER_BYTES = rfrs_pkg::DEFAULT_MIN_HEADER_BYTES,
   parameter int QUEUE_DEPTH      = rfrs_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   rfrs_req_if.sink          req_bus,
   rfrs_rsp_if.source        rsp_bus,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);
   import rfrs_pkg::*;

   logic          front_valid;
   logic          front_ready;
   rfrs_item_type front_item;
   logic          back_valid;
   logic          back_ready;
   rfrs_item_type back_item;

   rfrs_front #(
      .MIN_HEADER_BYTES(MIN_HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   rfrs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_item  (front_item),
      .in_ready (front_ready),
      .out_valid(back_valid),
      .out_item (back_item),
      .out_ready(back_ready)
   );

   rfrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(back_valid),
      .item      (back_item),
      .item_ready(back_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

@@ test/raw_frame_rx_stats_test.sv @@
`timescale 1ns / 100ps

module raw_frame_rx_stats_test;

   import rfrs_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 6;
   localparam int PHASE_FRAMES = 215;

   typedef struct {
      logic              is_data;
      logic [11:0]       len;
      logic [7:0]        proto_hi;
      logic [7:0]        proto_lo;
      logic [15:0]       seq_ctl;
      logic signed [7:0] rssi;
   } frame_t;

   typedef struct {
      logic              accepted;
      logic [31:0]       packets;
      logic [31:0]       bytes;
      logic [31:0]       lost;
      logic signed [7:0] rssi;
   } stats_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   rfrs_req_if req_bus ();
   rfrs_rsp_if rsp_bus ();

   raw_frame_rx_stats uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the statistics state.
   logic [15:0]       etype_model = ETHERTYPE_RESET;
   logic [31:0]       frame_count = '0;
   logic [31:0]       byte_sum = '0;
   logic [31:0]       lost_sum = '0;
   logic signed [7:0] rssi_hold = RSSI_NONE;
   logic [11:0]       prev_seq = '0;
   logic              seq_seen = 1'b0;

   frame_t frames_to_send[$];
   stats_t stats_due[$];
   frame_t on_bus;

   int   frames_queued = 0;
   int   frames_sent = 0;
   int   results_seen = 0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   bit   src_idle_on = 1'b0;
   bit   snk_idle_on = 1'b0;
   logic long_hold_req = 1'b0;
   logic [11:0] gen_seq = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Updates the shadow state for one frame and returns the statistics it produces.
   function automatic stats_t count_frame(input frame_t f);
      stats_t      s;
      logic [11:0] seq;
      logic [11:0] gap;
      s.accepted = f.is_data && (f.len >= DEFAULT_MIN_HEADER_BYTES)
                   && ({f.proto_hi, f.proto_lo} == etype_model);
      if (s.accepted) begin
         seq = f.seq_ctl[15:4];
         frame_count = frame_count + 32'd1;
         byte_sum = byte_sum + {20'd0, f.len};
         rssi_hold = f.rssi;
         if (seq_seen) begin
            gap = seq - prev_seq;
            // Gaps from half the sequence space upward count as reordering.
            if (gap > 12'd1 && gap < SEQ_HALF) begin
               lost_sum = lost_sum + {20'd0, gap} - 32'd1;
            end
         end
         prev_seq = seq;
         seq_seen = 1'b1;
      end
      s.packets = frame_count;
      s.bytes = byte_sum;
      s.lost = lost_sum;
      s.rssi = rssi_hold;
      return s;
   endfunction

   function automatic int idle_span();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   function automatic frame_t mk_frame(input logic is_data, input logic [11:0] len,
                                       input logic [7:0] hi, input logic [7:0] lo,
                                       input logic [11:0] seq, input logic [3:0] frag,
                                       input logic signed [7:0] rssi);
      frame_t f;
      f.is_data = is_data;
      f.len = len;
      f.proto_hi = hi;
      f.proto_lo = lo;
      f.seq_ctl = {seq, frag};
      f.rssi = rssi;
      return f;
   endfunction

   // Mostly well-formed frames for the current ethertype with a drifting sequence number.
   function automatic frame_t make_frame(input logic [15:0] etype);
      frame_t f;
      int     pick;
      int     step;
      pick = $urandom_range(0, 99);
      step = $urandom_range(0, 99);
      if (step < 55) begin
         step = 1;
      end else if (step < 65) begin
         step = 0;
      end else if (step < 80) begin
         step = $urandom_range(2, 12);
      end else if (step < 88) begin
         step = $urandom_range(13, 2047);
      end else begin
         step = $urandom_range(2048, 4095);
      end
      gen_seq = gen_seq + 12'(step);
      f.is_data = 1'b1;
      f.len = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(1601, 4095))
                                            : 12'($urandom_range(26, 1600));
      f.proto_hi = etype[15:8];
      f.proto_lo = etype[7:0];
      f.seq_ctl = {gen_seq, 4'($urandom_range(0, 15))};
      f.rssi = 8'($urandom_range(0, 255));
      if (pick >= 95) begin
         f.is_data = 1'($urandom_range(0, 1));
         f.len = 12'($urandom_range(0, 4095));
         f.proto_hi = 8'($urandom_range(0, 255));
         f.proto_lo = 8'($urandom_range(0, 255));
         f.seq_ctl = 16'($urandom_range(0, 65535));
      end else if (pick >= 91) begin
         f.len = 12'($urandom_range(0, 25));
      end else if (pick >= 88) begin
         f.is_data = 1'b0;
      end else if (pick >= 85) begin
         f.proto_hi = f.proto_hi ^ 8'(1 << $urandom_range(0, 7));
      end else if (pick >= 82) begin
         f.proto_lo = f.proto_lo ^ 8'(1 << $urandom_range(0, 7));
      end
      return f;
   endfunction

   task automatic push_frame(input frame_t f);
      frames_to_send.push_back(f);
      frames_queued++;
   endtask

   task automatic wait_idle();
      while (results_seen != frames_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ethertype(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      etype_model = value;
   endtask

   task automatic check_stats(input stats_t want);
      if (rsp_bus.accepted !== want.accepted) begin
         $error("accepted: expected %0d, got %0d", want.accepted, rsp_bus.accepted);
         error_count++;
      end
      if (rsp_bus.packets_total !== want.packets) begin
         $error("packets_total: expected %0d, got %0d", want.packets, rsp_bus.packets_total);
         error_count++;
      end
      if (rsp_bus.bytes_total !== want.bytes) begin
         $error("bytes_total: expected %0d, got %0d", want.bytes, rsp_bus.bytes_total);
         error_count++;
      end
      if (rsp_bus.lost_total !== want.lost) begin
         $error("lost_total: expected %0d, got %0d", want.lost, rsp_bus.lost_total);
         error_count++;
      end
      if (rsp_bus.rssi_last !== want.rssi) begin
         $error("rssi_last: expected %0d, got %0d", want.rssi, rsp_bus.rssi_last);
         error_count++;
      end
   endtask

   // Frame driver: the expectation is formed at the transfer edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            stats_due.push_back(count_frame(on_bus));
            frames_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (frames_to_send.size() > 0) begin
               on_bus = frames_to_send.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.is_data_frame <= on_bus.is_data;
               req_bus.frame_length <= on_bus.len;
               req_bus.proto_high <= on_bus.proto_hi;
               req_bus.proto_low <= on_bus.proto_lo;
               req_bus.seq_control <= on_bus.seq_ctl;
               req_bus.rssi_in <= on_bus.rssi;
               send_gap = (src_idle_on && $urandom_range(0, 3) == 0) ? idle_span() : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with its own stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (stats_due.size() == 0) begin
               $error("result transfer with no frame outstanding");
               error_count++;
            end else begin
               check_stats(stats_due.pop_front());
            end
         end
         if (long_hold_req) begin
            long_hold_req <= 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = idle_span() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] etype_list[PHASES];
      req_bus.valid = 1'b0;
      req_bus.is_data_frame = 1'b0;
      req_bus.frame_length = '0;
      req_bus.proto_high = '0;
      req_bus.proto_low = '0;
      req_bus.seq_control = '0;
      req_bus.rssi_in = '0;
      rsp_bus.ready = 1'b0;
      etype_list = '{ETHERTYPE_RESET, 16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), ETHERTYPE_RESET};

      wait (!reset);
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         // The first phase runs on the reset value of the ethertype.
         if (p > 0) begin
            set_ethertype(etype_list[p]);
         end
         src_idle_on = (p % 3) != 0;
         snk_idle_on = (p != 0) && (p != 3);
         if (p == 2) begin
            // Keep offering frames while the receiver holds off, so the queue fills.
            src_idle_on = 1'b0;
            long_hold_req <= 1'b1;
         end
         if (p == 0) begin
            push_frame(mk_frame(1'b1, 12'd26, 8'h88, 8'hB5, 12'd100, 4'h0, -8'sd128));
            push_frame(mk_frame(1'b1, 12'd25, 8'h88, 8'hB5, 12'd500, 4'h3, 8'sd5));
            push_frame(mk_frame(1'b0, 12'd1500, 8'h88, 8'hB5, 12'd600, 4'h0, 8'sd6));
            push_frame(mk_frame(1'b1, 12'd1500, 8'h89, 8'hB5, 12'd700, 4'h0, 8'sd7));
            push_frame(mk_frame(1'b1, 12'd1500, 8'h88, 8'hB4, 12'd800, 4'h0, 8'sd8));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd100, 4'h1, 8'sd127));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd101, 4'h0, -8'sd40));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd103, 4'h0, -8'sd41));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd2150, 4'h0, -8'sd42));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd102, 4'h0, -8'sd43));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd101, 4'h0, -8'sd44));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd4095, 4'h0, -8'sd45));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd0, 4'h0, -8'sd46));
            push_frame(mk_frame(1'b1, 12'd64, 8'h88, 8'hB5, 12'd2, 4'h0, -8'sd47));
            push_frame(mk_frame(1'b1, 12'd4095, 8'h88, 8'hB5, 12'd3, 4'hF, 8'sd0));
            push_frame(mk_frame(1'b0, 12'd0, 8'h00, 8'h00, 12'd0, 4'h0, 8'sd0));
            push_frame(mk_frame(1'b1, 12'd4095, 8'hFF, 8'hFF, 12'hFFF, 4'hF, -8'sd1));
            gen_seq = 12'd3;
         end
         repeat (PHASE_FRAMES) push_frame(make_frame(etype_model));
         wait_idle();
      end

      if (stats_due.size() != 0) begin
         $error("%0d expected results never arrived", stats_due.size());
         error_count++;
      end
      $display("Sent %0d frame descriptors under %0d ethertype settings, with one long stall.",
               frames_sent, PHASES);
      $display("Checked %0d results: %0d frames counted, %0d inferred lost.",
               results_seen, frame_count, lost_sum);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
